### design/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// shared types and constants of the substring search block
// ----------------------------------------------------------------------------
package nss_pkg;

   localparam int CHAR_W = 8;
   localparam int ACT_W  = 2;
   localparam int POS_W  = 7;

   typedef enum logic [ACT_W-1:0] {
      ACT_PATTERN = 2'd0,
      ACT_TEXT    = 2'd1,
      ACT_SEARCH  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SRCH_IDLE,
      SRCH_READ,
      SRCH_CMP,
      SRCH_HOLD
   } search_state_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } search_status_type;

endpackage

### design/nss_if.sv
// ----------------------------------------------------------------------------
// nss request and response channels
// valid/ready channels carrying the request and the search result
// ----------------------------------------------------------------------------
interface nss_req_if;
   logic                      valid;
   logic                      ready;
   logic [nss_pkg::ACT_W-1:0]  action;
   logic [nss_pkg::CHAR_W-1:0] char_in;

   modport source (output valid, output action, output char_in, input ready);
   modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface nss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [nss_pkg::POS_W-1:0] position;
   logic                      overflow;

   modport source (output valid, output found, output position, output overflow,
                   input ready);
   modport sink   (input valid, input found, input position, input overflow,
                   output ready);
endinterface

### design/naive_substring_search_top.sv
// ----------------------------------------------------------------------------
// naive_substring_search_top
// pattern and text stores with a first-occurrence search
// ----------------------------------------------------------------------------
//  channel  dir  payload                       transfer
//  req      in   action, char_in               valid && ready
//  rsp      out  found, position, overflow     valid && ready
//
//  an append is written on its transfer; a search is accepted, then steps
//  through each character compare as a registered store read and a compare,
//  and hands its result off to the rsp registers.
//  reset is synchronous and empties both stores; no clearing pass.
//  req is not ready while a search runs; appends and a new search are taken
//  while an earlier result still waits on rsp.
// ----------------------------------------------------------------------------
module naive_substring_search_top #(
   parameter int MAX_LEN = 128
) (
   input  logic     clock,
   input  logic     reset,
   nss_req_if.sink  req,
   nss_rsp_if.source rsp
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   logic [LW-1:0] plen_ff, plen_in;
   logic [LW-1:0] tlen_ff, tlen_in;
   logic          dropped_ff, dropped_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             found_ff;
   logic [nss_pkg::POS_W-1:0]        position_ff;
   logic                             overflow_ff;

   logic                             xfer;
   logic                             nonzero;
   logic                             pat_wr, txt_wr;
   logic                             go;
   logic                             out_free;
   logic                             ack;
   logic [AW-1:0]                    text_addr, pat_addr;
   logic [nss_pkg::CHAR_W-1:0]       text_data, pat_data;
   nss_pkg::search_status_type       status;

   assign req.ready = !status.busy;
   assign xfer      = req.valid && req.ready;
   assign nonzero   = (req.char_in != '0);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign ack       = status.done && out_free;

   always_comb begin
      pat_wr     = 1'b0;
      txt_wr     = 1'b0;
      go         = 1'b0;
      plen_in    = plen_ff;
      tlen_in    = tlen_ff;
      dropped_in = dropped_ff;
      if (xfer) begin
         case (req.action)
            nss_pkg::ACT_PATTERN: begin
               if (nonzero) begin
                  if (plen_ff == LW'(MAX_LEN)) begin
                     dropped_in = 1'b1;
                  end else begin
                     pat_wr  = 1'b1;
                     plen_in = plen_ff + LW'(1);
                  end
               end
            end
            nss_pkg::ACT_TEXT: begin
               if (nonzero) begin
                  if (tlen_ff == LW'(MAX_LEN)) begin
                     dropped_in = 1'b1;
                  end else begin
                     txt_wr  = 1'b1;
                     tlen_in = tlen_ff + LW'(1);
                  end
               end
            end
            nss_pkg::ACT_SEARCH: begin
               go = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (ack) begin
         plen_in    = '0;
         tlen_in    = '0;
         dropped_in = 1'b0;
      end
   end

   always_comb begin
      if (ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         tlen_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ack) begin
         found_ff    <= status.found;
         position_ff <= status.position;
         overflow_ff <= dropped_ff;
      end
   end

   nss_store #(
      .DEPTH (MAX_LEN),
      .AW    (AW)
   ) u_pat_store (
      .clock   (clock),
      .wr_en   (pat_wr),
      .wr_addr (plen_ff[AW-1:0]),
      .wr_data (req.char_in),
      .rd_addr (pat_addr),
      .rd_data (pat_data)
   );

   nss_store #(
      .DEPTH (MAX_LEN),
      .AW    (AW)
   ) u_txt_store (
      .clock   (clock),
      .wr_en   (txt_wr),
      .wr_addr (tlen_ff[AW-1:0]),
      .wr_data (req.char_in),
      .rd_addr (text_addr),
      .rd_data (text_data)
   );

   nss_search #(
      .LW      (LW),
      .AW      (AW)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .plen      (plen_ff),
      .tlen      (tlen_ff),
      .text_data (text_data),
      .pat_data  (pat_data),
      .ack       (ack),
      .text_addr (text_addr),
      .pat_addr  (pat_addr),
      .status    (status)
   );

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = found_ff;
   assign rsp.position = position_ff;
   assign rsp.overflow = overflow_ff;

endmodule

### design/nss_store.sv
// ----------------------------------------------------------------------------
// nss_store
// character memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module nss_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [nss_pkg::CHAR_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [nss_pkg::CHAR_W-1:0] rd_data
);

   logic [nss_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [nss_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/nss_search.sv
// ----------------------------------------------------------------------------
// nss_search
// search sequencer: walks start positions and pattern offsets through one
// shared character comparator
// ----------------------------------------------------------------------------
module nss_search #(
   parameter int LW      = 8,
   parameter int AW      = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [LW-1:0]               plen,
   input  logic [LW-1:0]               tlen,
   input  logic [nss_pkg::CHAR_W-1:0]  text_data,
   input  logic [nss_pkg::CHAR_W-1:0]  pat_data,
   input  logic                        ack,
   output logic [AW-1:0]               text_addr,
   output logic [AW-1:0]               pat_addr,
   output nss_pkg::search_status_type  status
);

   nss_pkg::search_state_type state_ff, state_in;
   logic [LW-1:0] start_ff, start_in;
   logic [LW-1:0] k_ff, k_in;
   logic          found_ff, found_in;

   logic [LW-1:0] text_sum;
   logic [LW-1:0] k_inc;
   logic [LW-1:0] start_end;
   logic [LW+nss_pkg::POS_W-1:0] start_ext;

   assign text_sum  = start_ff + k_ff;
   assign k_inc     = k_ff + LW'(1);
   assign start_end = start_ff + plen;
   assign start_ext = {{nss_pkg::POS_W{1'b0}}, start_ff};

   assign text_addr = text_sum[AW-1:0];
   assign pat_addr  = k_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nss_pkg::SRCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      k_ff     <= k_in;
      found_ff <= found_in;
   end

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      k_in     = k_ff;
      found_in = found_ff;
      case (state_ff)
         nss_pkg::SRCH_IDLE: begin
            start_in = '0;
            k_in     = '0;
            if (go) begin
               if (plen == '0) begin
                  found_in = 1'b1;
                  state_in = nss_pkg::SRCH_HOLD;
               end else if (plen > tlen) begin
                  found_in = 1'b0;
                  state_in = nss_pkg::SRCH_HOLD;
               end else begin
                  state_in = nss_pkg::SRCH_READ;
               end
            end
         end
         nss_pkg::SRCH_READ: begin
            state_in = nss_pkg::SRCH_CMP;
         end
         nss_pkg::SRCH_CMP: begin
            if (text_data == pat_data) begin
               if (k_inc == plen) begin
                  found_in = 1'b1;
                  state_in = nss_pkg::SRCH_HOLD;
               end else begin
                  k_in     = k_inc;
                  state_in = nss_pkg::SRCH_READ;
               end
            end else if (start_end == tlen) begin
               found_in = 1'b0;
               start_in = '0;
               state_in = nss_pkg::SRCH_HOLD;
            end else begin
               start_in = start_ff + LW'(1);
               k_in     = '0;
               state_in = nss_pkg::SRCH_READ;
            end
         end
         nss_pkg::SRCH_HOLD: begin
            if (ack) begin
               state_in = nss_pkg::SRCH_IDLE;
            end
         end
         default: begin
            state_in = nss_pkg::SRCH_IDLE;
         end
      endcase
   end

   always_comb begin
      status.busy     = (state_ff != nss_pkg::SRCH_IDLE);
      status.done     = (state_ff == nss_pkg::SRCH_HOLD);
      status.found    = found_ff;
      status.position = start_ext[nss_pkg::POS_W-1:0];
   end

endmodule

### design/nss_checker.sv
// ----------------------------------------------------------------------------
// nss_checker
// port-level checks of the substring search block, bound to the top level
// ----------------------------------------------------------------------------
module nss_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [nss_pkg::ACT_W-1:0]  req_action,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [nss_pkg::POS_W-1:0]  rsp_position,
   input logic                       rsp_overflow
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_position) && $stable(rsp_overflow))
      else $error("rsp payload changed while stalled");

   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss reported with nonzero position");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == nss_pkg::ACT_SEARCH |=> !req_ready)
      else $error("ready after search transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a search");

endmodule

bind naive_substring_search_top nss_checker u_nss_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_action   (req.action),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_found    (rsp.found),
   .rsp_position (rsp.position),
   .rsp_overflow (rsp.overflow)
);
